@@ src/lmpc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmpc_pkg
// Shared types and constants for the LED mode and pattern controller.
// ----------------------------------------------------------------------------
package lmpc_pkg;

    localparam int CNT_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_TICKS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_LOCKOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOCKOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_TICKS      = 3'd5;

    // Register values after reset
    localparam logic [CNT_W-1:0]   BLINK_TICKS_RST    = 16'd200;
    localparam logic [CNT_W-1:0]   FADE_TICKS_RST     = 16'd15;
    localparam logic [CNT_W-1:0]   MODE_LOCKOUT_RST   = 16'd300;
    localparam logic [CNT_W-1:0]   RESET_LOCKOUT_RST  = 16'd200;
    localparam logic [LEVEL_W-1:0] FADE_STEP_RST      = 8'd5;
    localparam logic [LEVEL_W-1:0] PWM_TICKS_RST      = 8'd10;

    // Modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_BLINK = 2'd1;
    localparam logic [1:0] MODE_ON    = 2'd2;
    localparam logic [1:0] MODE_FADE  = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    typedef struct packed {
        logic [CNT_W-1:0]   blink_ticks;
        logic [CNT_W-1:0]   fade_ticks;
        logic [CNT_W-1:0]   mode_lockout;
        logic [CNT_W-1:0]   reset_lockout;
        logic [LEVEL_W-1:0] fade_step;
        logic [LEVEL_W-1:0] pwm_ticks;
    } t_cfg;

    typedef struct packed {
        logic       red_on;
        logic       green_on;
        logic       blue_on;
        logic [1:0] current_mode;
    } t_result;

endpackage

@@ src/lmpc_if.sv @@
// ----------------------------------------------------------------------------
// lmpc_if
// Valid/ready channels for button ticks and LED results.
// ----------------------------------------------------------------------------
interface lmpc_in_if;
    logic valid;
    logic ready;
    logic mode_pressed;
    logic reset_pressed;

    modport source (output valid, output mode_pressed, output reset_pressed, input ready);
    modport sink   (input valid, input mode_pressed, input reset_pressed, output ready);
endinterface

interface lmpc_out_if;
    logic       valid;
    logic       ready;
    logic       red_on;
    logic       green_on;
    logic       blue_on;
    logic [1:0] current_mode;

    modport source (output valid, output red_on, output green_on, output blue_on,
                    output current_mode, input ready);
    modport sink   (input valid, input red_on, input green_on, input blue_on,
                    input current_mode, output ready);
endinterface

@@ src/lmpc_core.sv @@
// ----------------------------------------------------------------------------
// lmpc_core
// Pattern state and the single-tick update: lockouts, mode, blink, fade, PWM.
// ----------------------------------------------------------------------------
module lmpc_core
    import lmpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_mode_pressed,
    input  logic    i_reset_pressed,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [1:0]         r_mode, n_mode;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               r_falling, n_falling;
    logic [1:0]         r_pos, n_pos;
    logic [CNT_W-1:0]   r_since_blink, n_since_blink;
    logic [CNT_W-1:0]   r_since_fade, n_since_fade;
    logic [CNT_W-1:0]   r_since_mode, n_since_mode;
    logic [CNT_W-1:0]   r_since_reset, n_since_reset;
    logic [LEVEL_W-1:0] r_phase, n_phase;
    logic [2:0]         r_latch, n_latch;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    logic [LEVEL_W:0]     phase_inc;
    logic [LEVEL_W:0]     level_sum;
    logic [2*LEVEL_W-1:0] product;
    logic [2*LEVEL_W:0]   quot_sum;
    logic [LEVEL_W-1:0]   duty;

    always_comb begin
        n_mode        = r_mode;
        n_level       = r_level;
        n_falling     = r_falling;
        n_pos         = r_pos;
        n_latch       = r_latch;
        n_since_blink = sat_inc(r_since_blink);
        n_since_fade  = sat_inc(r_since_fade);
        n_since_mode  = sat_inc(r_since_mode);
        n_since_reset = sat_inc(r_since_reset);
        level_sum     = '0;
        product       = '0;
        quot_sum      = '0;
        duty          = '0;

        // Phase wraps once it reaches the period; a period of 0 holds it at 0
        phase_inc = {1'b0, r_phase} + 1'b1;
        n_phase   = (phase_inc >= {1'b0, i_cfg.pwm_ticks}) ? '0 : phase_inc[LEVEL_W-1:0];

        if (i_reset_pressed && (n_since_reset >= i_cfg.reset_lockout)) begin
            n_since_reset = '0;
            n_mode        = MODE_OFF;
            n_level       = '0;
            n_falling     = 1'b0;
            n_pos         = '0;
            n_latch       = '0;
        end else begin
            if (i_mode_pressed && (n_since_mode >= i_cfg.mode_lockout)) begin
                n_since_mode  = '0;
                n_mode        = r_mode + 1'b1;
                n_latch       = '0;
                n_level       = '0;
                n_falling     = 1'b0;
                n_pos         = '0;
                n_since_blink = '0;
                n_since_fade  = '0;
            end
            case (n_mode)
                MODE_OFF: begin
                    n_latch = '0;
                end
                MODE_BLINK: begin
                    if (n_since_blink >= i_cfg.blink_ticks) begin
                        n_since_blink = '0;
                        n_latch = (n_pos == 2'd3) ? 3'b000 : (3'b001 << n_pos);
                        n_pos   = (n_pos >= 2'd2) ? 2'd0 : n_pos + 1'b1;
                    end
                end
                MODE_ON: begin
                    n_latch = 3'b111;
                end
                default: begin
                    if (n_since_fade >= i_cfg.fade_ticks) begin
                        n_since_fade = '0;
                        if (n_falling) begin
                            if (n_level <= i_cfg.fade_step) begin
                                n_level   = '0;
                                n_falling = 1'b0;
                            end else begin
                                n_level = n_level - i_cfg.fade_step;
                            end
                        end else begin
                            level_sum = {1'b0, n_level} + {1'b0, i_cfg.fade_step};
                            if (level_sum >= {1'b0, LEVEL_MAX}) begin
                                n_level   = LEVEL_MAX;
                                n_falling = 1'b1;
                            end else begin
                                n_level = level_sum[LEVEL_W-1:0];
                            end
                        end
                    end
                    // Divide by 255 through x/255 = (x + x/256 + 1) / 256, exact in range
                    product  = n_level * i_cfg.pwm_ticks;
                    quot_sum = {1'b0, product} + {{(LEVEL_W+1){1'b0}}, product[2*LEVEL_W-1:LEVEL_W]}
                               + 1'b1;
                    duty     = quot_sum[2*LEVEL_W-1:LEVEL_W];
                    n_latch  = (r_phase < duty) ? 3'b111 : 3'b000;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OFF;
            r_level       <= '0;
            r_falling     <= 1'b0;
            r_pos         <= '0;
            r_since_blink <= '0;
            r_since_fade  <= '0;
            r_since_mode  <= '0;
            r_since_reset <= '0;
            r_phase       <= '0;
            r_latch       <= '0;
        end else if (i_accept) begin
            r_mode        <= n_mode;
            r_level       <= n_level;
            r_falling     <= n_falling;
            r_pos         <= n_pos;
            r_since_blink <= n_since_blink;
            r_since_fade  <= n_since_fade;
            r_since_mode  <= n_since_mode;
            r_since_reset <= n_since_reset;
            r_phase       <= n_phase;
            r_latch       <= n_latch;
        end
    end

    // Result of the tick being accepted, registered by the output buffer
    assign o_result.red_on       = n_latch[0];
    assign o_result.green_on     = n_latch[1];
    assign o_result.blue_on      = n_latch[2];
    assign o_result.current_mode = n_mode;

endmodule

@@ src/lmpc_out_buf.sv @@
// ----------------------------------------------------------------------------
// lmpc_out_buf
// Two-entry result buffer that decouples the input side from output stalls.
// ----------------------------------------------------------------------------
module lmpc_out_buf
    import lmpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_space = ~r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

@@ src/led_mode_pattern_controller.sv @@
// ----------------------------------------------------------------------------
// led_mode_pattern_controller
// Mode button / reset button tick processor driving three LEDs.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one millisecond tick per transfer, with the levels of the
//   mode and reset buttons. o_result returns exactly one transfer per tick:
//   the red, green and blue drive and the current mode (off, rotating blink,
//   all on, breathing fade).
//   Throughput is one tick per clock while the result buffer has room. The
//   whole tick update (lockout counters, mode advance, blink step, fade step,
//   PWM compare) settles between the state registers and the result buffer,
//   which registers each result at its tick transfer, behind any waiting one.
//   The result buffer holds two entries, so a tick is taken while a result
//   waits; i_item.ready drops only when both entries are full, and then the
//   block holds all state until the receiver drains a result.
//   Configuration registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_data while no tick is in flight; unknown indexes are dropped.
//   Reset (i_rst_n low, synchronous) loads the default intervals and
//   lockouts, clears all pattern state and empties the result buffer.
// ----------------------------------------------------------------------------
module led_mode_pattern_controller
    import lmpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lmpc_in_if.sink               i_item,
    lmpc_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_result core_result;
    t_result buf_data;
    logic    buf_space;
    logic    buf_valid;
    logic    item_xfer;
    logic    result_xfer;

    // Configuration: write by index, drop anything beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_ticks    <= BLINK_TICKS_RST;
            r_cfg.fade_ticks     <= FADE_TICKS_RST;
            r_cfg.mode_lockout   <= MODE_LOCKOUT_RST;
            r_cfg.reset_lockout  <= RESET_LOCKOUT_RST;
            r_cfg.fade_step      <= FADE_STEP_RST;
            r_cfg.pwm_ticks      <= PWM_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLINK_TICKS:    r_cfg.blink_ticks    <= i_cfg_data;
                REG_FADE_TICKS:     r_cfg.fade_ticks     <= i_cfg_data;
                REG_MODE_LOCKOUT:   r_cfg.mode_lockout   <= i_cfg_data;
                REG_RESET_LOCKOUT:  r_cfg.reset_lockout  <= i_cfg_data;
                REG_FADE_STEP:      r_cfg.fade_step      <= i_cfg_data[LEVEL_W-1:0];
                REG_PWM_TICKS:      r_cfg.pwm_ticks      <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Take a tick whenever the result buffer has room
    assign i_item.ready = buf_space;
    assign item_xfer    = i_item.valid & buf_space;
    assign result_xfer  = buf_valid & o_result.ready;

    lmpc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (item_xfer),
        .i_mode_pressed  (i_item.mode_pressed),
        .i_reset_pressed (i_item.reset_pressed),
        .i_cfg           (r_cfg),
        .o_result        (core_result)
    );

    lmpc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_xfer),
        .i_data  (core_result),
        .o_space (buf_space),
        .o_valid (buf_valid),
        .i_pop   (result_xfer),
        .o_data  (buf_data)
    );

    assign o_result.valid        = buf_valid;
    assign o_result.red_on       = buf_data.red_on;
    assign o_result.green_on     = buf_data.green_on;
    assign o_result.blue_on      = buf_data.blue_on;
    assign o_result.current_mode = buf_data.current_mode;

endmodule

@@ sim/led_mode_pattern_controller_tb.sv @@
// ----------------------------------------------------------------------------
// led_mode_pattern_controller_tb
// Self-checking bench for the LED mode and pattern controller. Button ticks
// are pushed through the input channel in random bursts, and every LED
// result is compared field by field against a cycle-free tick model kept in
// the bench. The receiver stalls on its own pattern, including long
// hold-offs that back the block up. The registers are rewritten between
// phases while the block is drained.
// ----------------------------------------------------------------------------
module led_mode_pattern_controller_tb;
    import lmpc_pkg::*;

    // Indexes past the end of the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int HOLDOFF_CYCLES = 250;
    localparam int PHASE_COUNT    = 8;

    typedef struct {
        logic mode_btn;
        logic rst_btn;
    } t_tick;

    // Receiver stall styles
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_style;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lmpc_in_if  in_ch ();
    lmpc_out_if out_ch ();

    led_mode_pattern_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (in_ch),
        .o_result    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Ticks waiting to be offered, and LED results waiting to come back
    t_tick   tick_q[$];
    t_result led_expect_q[$];
    int      fail_cnt = 0;

    // Register copy of the tick model
    logic [CNT_W-1:0]   cfg_blink_iv;
    logic [CNT_W-1:0]   cfg_fade_iv;
    logic [CNT_W-1:0]   cfg_mode_lock;
    logic [CNT_W-1:0]   cfg_rst_lock;
    logic [LEVEL_W-1:0] cfg_fade_step;
    logic [LEVEL_W-1:0] cfg_pwm_ticks;

    // Pattern state of the tick model
    logic [1:0]         m_mode;
    logic [LEVEL_W-1:0] m_level;
    logic               m_falling;
    logic [1:0]         m_blink_pos;
    logic [CNT_W-1:0]   m_since_blink;
    logic [CNT_W-1:0]   m_since_fade;
    logic [CNT_W-1:0]   m_since_mode;
    logic [CNT_W-1:0]   m_since_rst;
    logic [LEVEL_W-1:0] m_phase;
    logic [2:0]         m_leds;

    // Driver and receiver bookkeeping
    int        burst_left = 0;
    int        gap_left = 0;
    t_tick     drv_tick;
    int        holdoff_req = 0;
    int        holdoff_seen = 0;
    int        holdoff_left = 0;
    int        rx_seg_left = 0;
    t_rx_style rx_style = RX_ALWAYS;
    logic      rx_ready;

    // ------------------------------------------------------------------------
    // Clock and time limit
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Far beyond the slowest legal run: ~1650 ticks, each with a max gap and
    // a sparse receiver, plus the long hold-offs and the drains between phases.
    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tick model
    // ------------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    task automatic reset_led_model();
        cfg_blink_iv   = BLINK_TICKS_RST;
        cfg_fade_iv    = FADE_TICKS_RST;
        cfg_mode_lock  = MODE_LOCKOUT_RST;
        cfg_rst_lock   = RESET_LOCKOUT_RST;
        cfg_fade_step  = FADE_STEP_RST;
        cfg_pwm_ticks  = PWM_TICKS_RST;
        m_mode        = MODE_OFF;
        m_level       = '0;
        m_falling     = 1'b0;
        m_blink_pos   = '0;
        m_since_blink = '0;
        m_since_fade  = '0;
        m_since_mode  = '0;
        m_since_rst   = '0;
        m_phase       = '0;
        m_leds        = '0;
    endtask

    // Advance the model by one tick and return the LED result it shows
    function t_result step_led_model(input logic mode_btn, input logic rst_btn);
        logic [LEVEL_W-1:0] phase_now;
        logic [LEVEL_W:0]   phase_next;
        logic [LEVEL_W:0]   level_sum;
        logic [15:0]        duty;
        t_result            res;
        phase_now  = m_phase;
        phase_next = {1'b0, m_phase} + 1'b1;
        m_phase    = (phase_next >= {1'b0, cfg_pwm_ticks}) ? '0 : phase_next[LEVEL_W-1:0];

        m_since_blink = sat_up(m_since_blink);
        m_since_fade  = sat_up(m_since_fade);
        m_since_mode  = sat_up(m_since_mode);
        m_since_rst   = sat_up(m_since_rst);

        if (rst_btn && m_since_rst >= cfg_rst_lock) begin
            // reset press wins and ends the tick
            m_since_rst = '0;
            m_mode      = MODE_OFF;
            m_level     = '0;
            m_falling   = 1'b0;
            m_blink_pos = '0;
            m_leds      = '0;
        end else begin
            if (mode_btn && m_since_mode >= cfg_mode_lock) begin
                m_since_mode  = '0;
                m_mode        = m_mode + 2'd1;
                m_leds        = '0;
                m_level       = '0;
                m_falling     = 1'b0;
                m_blink_pos   = '0;
                m_since_blink = '0;
                m_since_fade  = '0;
            end
            case (m_mode)
                MODE_OFF: begin
                    m_leds = '0;
                end
                MODE_BLINK: begin
                    if (m_since_blink >= cfg_blink_iv) begin
                        m_since_blink = '0;
                        m_leds = (m_blink_pos < 2'd3) ? (3'b001 << m_blink_pos) : 3'b000;
                        m_blink_pos = (m_blink_pos >= 2'd2) ? 2'd0 : m_blink_pos + 2'd1;
                    end
                end
                MODE_ON: begin
                    m_leds = 3'b111;
                end
                default: begin
                    if (m_since_fade >= cfg_fade_iv) begin
                        m_since_fade = '0;
                        if (m_falling) begin
                            if (m_level <= cfg_fade_step) begin
                                m_level   = '0;
                                m_falling = 1'b0;
                            end else begin
                                m_level = m_level - cfg_fade_step;
                            end
                        end else begin
                            level_sum = {1'b0, m_level} + {1'b0, cfg_fade_step};
                            if (level_sum >= {1'b0, LEVEL_MAX}) begin
                                m_level   = LEVEL_MAX;
                                m_falling = 1'b1;
                            end else begin
                                m_level = level_sum[LEVEL_W-1:0];
                            end
                        end
                    end
                    duty   = (16'(m_level) * 16'(cfg_pwm_ticks)) / 16'd255;
                    m_leds = (16'(phase_now) < duty) ? 3'b111 : 3'b000;
                end
            endcase
        end

        res.red_on       = m_leds[0];
        res.green_on     = m_leds[1];
        res.blue_on      = m_leds[2];
        res.current_mode = m_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration and drain helpers
    // ------------------------------------------------------------------------
    // Write one register; the model copy follows at once since nothing is
    // in flight while registers change.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_BLINK_TICKS:    cfg_blink_iv   = data;
            REG_FADE_TICKS:     cfg_fade_iv    = data;
            REG_MODE_LOCKOUT:   cfg_mode_lock  = data;
            REG_RESET_LOCKOUT:  cfg_rst_lock   = data;
            REG_FADE_STEP:      cfg_fade_step  = data[LEVEL_W-1:0];
            REG_PWM_TICKS:      cfg_pwm_ticks  = data[LEVEL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [CNT_W-1:0] blink_iv,
                                  input logic [CNT_W-1:0] fade_iv,
                                  input logic [CNT_W-1:0] mode_lock,
                                  input logic [CNT_W-1:0] rst_lock,
                                  input logic [LEVEL_W-1:0] fade_step,
                                  input logic [LEVEL_W-1:0] pwm_ticks);
        write_reg(REG_BLINK_TICKS, blink_iv);
        write_reg(REG_FADE_TICKS, fade_iv);
        write_reg(REG_MODE_LOCKOUT, mode_lock);
        write_reg(REG_RESET_LOCKOUT, rst_lock);
        write_reg(REG_FADE_STEP, CFG_DATA_W'(fade_step));
        write_reg(REG_PWM_TICKS, CFG_DATA_W'(pwm_ticks));
        @(negedge i_clk);
    endtask

    // Hold until every tick is transferred and every result is back, then
    // let the pipeline settle.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (tick_q.size() != 0 || in_ch.valid || led_expect_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_tick(input logic mode_btn, input logic rst_btn);
        t_tick t;
        t.mode_btn = mode_btn;
        t.rst_btn  = rst_btn;
        tick_q.push_back(t);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer queued ticks in bursts with random gaps between them
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!(in_ch.valid && !in_ch.ready)) begin
            // free to move on: the last tick was transferred or none was offered
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                drv_tick = tick_q.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.mode_pressed  <= drv_tick.mode_btn;
                in_ch.reset_pressed <= drv_tick.rst_btn;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // start a new burst: mostly short, sometimes a long run with no gap
                    burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(0, 8);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, plus requested long hold-offs
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (holdoff_left > 0) begin
                holdoff_left--;
                rx_ready = 1'b0;
            end else if (holdoff_req != holdoff_seen) begin
                holdoff_seen = holdoff_req;
                holdoff_left = HOLDOFF_CYCLES;
                rx_ready     = 1'b0;
            end else begin
                if (rx_seg_left == 0) begin
                    rx_style    = t_rx_style'($urandom_range(3));
                    rx_seg_left = $urandom_range(10, 80);
                end else begin
                    rx_seg_left--;
                end
                case (rx_style)
                    RX_ALWAYS: rx_ready = 1'b1;
                    RX_COIN:   rx_ready = 1'($urandom_range(1));
                    RX_SPARSE: rx_ready = ($urandom_range(3) == 0);
                    default:   rx_ready = rx_seg_left[0];
                endcase
            end
            out_ch.ready <= rx_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check result transfers first, then predict for tick transfers
    // at the same edge, so a result is never matched against its own tick.
    // ------------------------------------------------------------------------
    t_result seen_res;
    t_result want_res;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                seen_res.red_on       = out_ch.red_on;
                seen_res.green_on     = out_ch.green_on;
                seen_res.blue_on      = out_ch.blue_on;
                seen_res.current_mode = out_ch.current_mode;
                if (led_expect_q.size() == 0) begin
                    $error("result transfer with no tick pending: %b", seen_res);
                    fail_cnt++;
                end else begin
                    want_res = led_expect_q.pop_front();
                    if (seen_res.red_on !== want_res.red_on) begin
                        $error("red_on mismatch: expected %0d, actual %0d",
                               want_res.red_on, seen_res.red_on);
                        fail_cnt++;
                    end
                    if (seen_res.green_on !== want_res.green_on) begin
                        $error("green_on mismatch: expected %0d, actual %0d",
                               want_res.green_on, seen_res.green_on);
                        fail_cnt++;
                    end
                    if (seen_res.blue_on !== want_res.blue_on) begin
                        $error("blue_on mismatch: expected %0d, actual %0d",
                               want_res.blue_on, seen_res.blue_on);
                        fail_cnt++;
                    end
                    if (seen_res.current_mode !== want_res.current_mode) begin
                        $error("current_mode mismatch: expected %0d, actual %0d",
                               want_res.current_mode, seen_res.current_mode);
                        fail_cnt++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                led_expect_q.push_back(step_led_model(in_ch.mode_pressed, in_ch.reset_pressed));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    int phase_ticks;
    int mode_pct;
    int rst_pct;
    logic [CNT_W-1:0]   set_bi, set_fi, set_ml, set_rl;
    logic [LEVEL_W-1:0] set_fs, set_pp;

    initial begin
        // drive every input to a known level before the first edge
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.mode_pressed  = 1'b0;
        in_ch.reset_pressed = 1'b0;
        out_ch.ready        = 1'b0;
        reset_led_model();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default registers: neither lockout has run out yet, so every press drops
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        wait_drained();

        // Fastest pattern settings with zero lockouts and full step and period;
        // writes past the register list must leave everything alone.
        write_all_regs(16'd1, 16'd1, 16'd0, 16'd0, LEVEL_MAX, LEVEL_MAX);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        @(negedge i_clk);
        push_tick(1'b1, 1'b0);          // enter blink, nothing lit yet
        push_tick(1'b0, 1'b0);          // red
        push_tick(1'b0, 1'b0);          // green
        push_tick(1'b0, 1'b0);          // blue
        push_tick(1'b0, 1'b0);          // wrap back to red
        push_tick(1'b1, 1'b0);          // all on
        push_tick(1'b1, 1'b0);          // fade, level still zero
        push_tick(1'b0, 1'b0);          // clamp at the top, turn to falling
        push_tick(1'b0, 1'b0);          // clamp at zero, turn to rising
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);          // reset beats a mode press in the same tick
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);          // mode wraps from fade to off
        push_tick(1'b0, 1'b0);
        wait_drained();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            phase_ticks = 200;
            mode_pct    = 30;
            rst_pct     = 4;
            case (ph)
                0: begin
                    // back to the reset values
                    set_bi = BLINK_TICKS_RST;    set_fi = FADE_TICKS_RST;
                    set_ml = MODE_LOCKOUT_RST;   set_rl = RESET_LOCKOUT_RST;
                    set_fs = FADE_STEP_RST;      set_pp = PWM_TICKS_RST;
                    phase_ticks = 150;
                    mode_pct    = 50;
                end
                1: begin
                    set_bi = 16'd3;  set_fi = 16'd1; set_ml = 16'd40; set_rl = 16'd100;
                    set_fs = 8'd17;  set_pp = 8'd7;
                end
                2: begin
                    // upper extremes: counters run, nothing is accepted
                    set_bi = 16'hFFFF; set_fi = 16'hFFFF; set_ml = 16'hFFFF; set_rl = 16'hFFFF;
                    set_fs = LEVEL_MAX; set_pp = LEVEL_MAX;
                    phase_ticks = 100;
                end
                3: begin
                    // all zero: every event fires each tick, fade frozen, PWM dark
                    set_bi = '0; set_fi = '0; set_ml = '0; set_rl = '0;
                    set_fs = '0; set_pp = '0;
                    phase_ticks = 100;
                    rst_pct     = 2;
                end
                4: begin
                    set_bi = 16'd1;  set_fi = 16'd2; set_ml = 16'd10; set_rl = 16'd25;
                    set_fs = 8'd1;   set_pp = LEVEL_MAX;
                    phase_ticks = 300;
                    mode_pct    = 15;
                    rst_pct     = 2;
                end
                5: begin
                    set_bi = 16'd5;  set_fi = 16'd1; set_ml = 16'd60; set_rl = 16'd200;
                    set_fs = 8'd64;  set_pp = 8'd10;
                    phase_ticks = 300;
                end
                6: begin
                    set_bi = CNT_W'($urandom_range(1, 12));
                    set_fi = CNT_W'($urandom_range(1, 6));
                    set_ml = CNT_W'($urandom_range(0, 50));
                    set_rl = CNT_W'($urandom_range(0, 120));
                    set_fs = LEVEL_W'($urandom_range(1, 255));
                    set_pp = LEVEL_W'($urandom_range(1, 20));
                    phase_ticks = 300;
                end
                default: begin
                    set_bi = CNT_W'($urandom_range(0, 8));
                    set_fi = CNT_W'($urandom_range(0, 8));
                    set_ml = CNT_W'($urandom_range(0, 30));
                    set_rl = CNT_W'($urandom_range(0, 60));
                    set_fs = LEVEL_W'($urandom_range(0, 255));
                    set_pp = LEVEL_W'($urandom_range(0, 255));
                    phase_ticks = 180;
                    rst_pct     = 3;
                end
            endcase
            write_all_regs(set_bi, set_fi, set_ml, set_rl, set_fs, set_pp);

            for (int n = 0; n < phase_ticks; n++) begin
                push_tick($urandom_range(99) < mode_pct, $urandom_range(99) < rst_pct);
            end
            // back the block up: the receiver goes quiet while ticks keep coming
            if (ph == 1 || ph == 5) begin
                holdoff_req++;
            end
            wait_drained();
        end

        // let any stray late result show up before the verdict
        repeat (10) @(negedge i_clk);
        if (fail_cnt == 0 && led_expect_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
